[rtl/crclf_pkg.sv]
// shared types, constants and the byte-wise crc-32 update for the length framer
// no dependencies
package crclf_pkg;

	localparam logic [31:0] CRC_POLY_REFL = 32'hEDB8_8320;
	localparam logic [31:0] CRC_ALL_ONES  = 32'hFFFF_FFFF;
	localparam logic [7:0]  SYNC_RESET    = 8'hED;
	localparam logic [15:0] LEN_EXTRA     = 16'd4;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_SYNC = 2'd0,
		KIND_LEN  = 2'd1,
		KIND_DATA = 2'd2,
		KIND_CRC  = 2'd3
	} kind_t;

	// position inside the full result sequence of one item
	typedef logic [2:0] step_t;
	localparam step_t STEP_SYNC   = 3'd0;
	localparam step_t STEP_LEN_LO = 3'd1;
	localparam step_t STEP_LEN_HI = 3'd2;
	localparam step_t STEP_DATA   = 3'd3;
	localparam step_t STEP_CRC0   = 3'd4;
	localparam step_t STEP_CRC1   = 3'd5;
	localparam step_t STEP_CRC2   = 3'd6;
	localparam step_t STEP_CRC3   = 3'd7;

	// one classified request between front and back
	typedef struct packed {
		logic [7:0]  data;
		logic        first;
		logic        final_byte;
		logic [15:0] len;
		logic [7:0]  sync;
		logic [31:0] crc;
	} item_t;

	// queue head as seen by the back part
	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	function automatic logic [31:0] crc_feed(input logic [31:0] acc, input logic [7:0] b);
		logic [31:0] c;
		c = acc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
		end
		return c;
	endfunction

endpackage

[rtl/crclf_front.sv]
// front part: takes input requests, runs the crc and builds queue entries
// depends on crclf_pkg
module crclf_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [7:0]           cfg_wdata,
	input  logic                 take,
	input  logic [7:0]           payload_byte,
	input  logic                 is_first,
	input  logic                 is_final,
	input  logic [15:0]          byte_count,
	output crclf_pkg::item_t     item
);
	import crclf_pkg::*;

	logic [31:0] crc_q;
	logic [7:0]  sync_q;
	logic [31:0] crc_next;

	assign crc_next = crc_feed(is_first ? CRC_ALL_ONES : crc_q, payload_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= CRC_ALL_ONES;
			sync_q <= SYNC_RESET;
		end else begin
			if (cfg_we) begin
				sync_q <= cfg_wdata;
			end
			if (take) begin
				crc_q <= is_final ? CRC_ALL_ONES : crc_next;
			end
		end
	end

	always_comb begin
		item.data       = payload_byte;
		item.first      = is_first;
		item.final_byte = is_final;
		item.len        = byte_count + LEN_EXTRA;   // wraps modulo 2^16
		item.sync       = sync_q;
		item.crc        = ~crc_next;
	end

endmodule

[rtl/crclf_queue.sv]
// short queue that decouples the front part from the back part
// depends on crclf_pkg
module crclf_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr,
	input  crclf_pkg::item_t     wr_item,
	output logic                 full,
	input  logic                 rd,
	output crclf_pkg::head_t     head
);
	import crclf_pkg::*;

	item_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_rd;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];
	assign do_rd      = rd && head.valid;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/crclf_back.sv]
// back part: steps through the results of each queued request into the output register
// depends on crclf_pkg
module crclf_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  crclf_pkg::head_t     head,
	output logic                 deq,
	input  logic                 pop,
	output logic                 empty,
	output logic [7:0]           out_byte,
	output logic [1:0]           byte_kind,
	output logic                 frame_done,
	output logic                 run_last
);
	import crclf_pkg::*;

	logic       busy_q;
	step_t      step_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	kind_t      kind_q;
	logic       done_q;
	logic       last_q;

	step_t      pos;
	logic       pos_last;
	logic       load;
	logic [7:0] res_byte;
	kind_t      res_kind;

	// a request without first skips the header steps
	assign pos      = busy_q ? step_q : (head.item.first ? STEP_SYNC : STEP_DATA);
	assign pos_last = (pos == (head.item.final_byte ? STEP_CRC3 : STEP_DATA));
	assign load     = head.valid && (!out_valid_q || pop);
	assign deq      = load && pos_last;

	always_comb begin
		res_byte = head.item.data;
		res_kind = KIND_DATA;
		case (pos)
			STEP_SYNC: begin
				res_byte = head.item.sync;
				res_kind = KIND_SYNC;
			end
			STEP_LEN_LO: begin
				res_byte = head.item.len[7:0];
				res_kind = KIND_LEN;
			end
			STEP_LEN_HI: begin
				res_byte = head.item.len[15:8];
				res_kind = KIND_LEN;
			end
			STEP_CRC0: begin
				res_byte = head.item.crc[7:0];
				res_kind = KIND_CRC;
			end
			STEP_CRC1: begin
				res_byte = head.item.crc[15:8];
				res_kind = KIND_CRC;
			end
			STEP_CRC2: begin
				res_byte = head.item.crc[23:16];
				res_kind = KIND_CRC;
			end
			STEP_CRC3: begin
				res_byte = head.item.crc[31:24];
				res_kind = KIND_CRC;
			end
			default: begin
				res_byte = head.item.data;
				res_kind = KIND_DATA;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= STEP_SYNC;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				busy_q      <= !pos_last;
				step_q      <= pos + 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= res_byte;
			kind_q <= res_kind;
			done_q <= (pos == STEP_CRC3);
			last_q <= pos_last;
		end
	end

	assign empty      = !out_valid_q;
	assign out_byte   = byte_q;
	assign byte_kind  = kind_q;
	assign frame_done = done_q;
	assign run_last   = last_q;

endmodule

[rtl/crc32_length_framer.sv]
// top level of the crc-32 length framer: front, request queue and back
// depends on crclf_pkg, crclf_front, crclf_queue, crclf_back
//
// usage
// input side is a queue write port: a byte is taken at a clock edge with push high
// and full low. is_first marks the first payload byte and carries byte_count; the
// framer then puts sync, length low and length high ahead of it. is_final marks the
// last payload byte and appends the four crc-32 bytes, least significant first.
// result side is a queue read port: while empty is low the oldest result byte is on
// out_byte/byte_kind/frame_done/run_last and it is taken at an edge with pop high.
// cfg_we/cfg_wdata write the sync byte; write it only while the block is idle.
// the first result of a byte passes through the request queue and then the output register.
// one result per cycle at the output register while pop stays high; a byte that gives n
// results (1 to 8) holds the result sequencer until all n are loaded, so plain payload
// bytes go through at one per cycle unless pop stalls. the crc update is a byte-wise step.
// a four-entry request queue lets input keep flowing while headers or crc bytes
// drain, and full rises only when that queue is full.
// reset: crc register to all ones, sync byte to 0xed, queue and output emptied.
// when pop stays low the output byte holds and the queue fills, then full is raised.
module crc32_length_framer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  payload_byte,
	input  logic        is_first,
	input  logic        is_final,
	input  logic [15:0] byte_count,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic [1:0]  byte_kind,
	output logic        frame_done,
	output logic        run_last
);
	import crclf_pkg::*;

	item_t item;
	head_t head;
	logic  take;
	logic  deq;

	assign take = push && !full;

	crclf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.take         (take),
		.payload_byte (payload_byte),
		.is_first     (is_first),
		.is_final     (is_final),
		.byte_count   (byte_count),
		.item         (item)
	);

	crclf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (take),
		.wr_item (item),
		.full    (full),
		.rd      (deq),
		.head    (head)
	);

	crclf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.deq        (deq),
		.pop        (pop),
		.empty      (empty),
		.out_byte   (out_byte),
		.byte_kind  (byte_kind),
		.frame_done (frame_done),
		.run_last   (run_last)
	);

endmodule

[rtl/crclf_checker.sv]
// port-level checks for the crc-32 length framer, bound to the top level
// depends on crclf_pkg and crc32_length_framer
module crclf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_byte,
	input logic [1:0] byte_kind,
	input logic       frame_done,
	input logic       run_last
);
	import crclf_pkg::*;

	// a waiting result holds until it is taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_byte) && $stable(byte_kind))
		else $error("result changed while stalled");

	// the closing crc byte ends the request's results
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && frame_done |-> byte_kind == KIND_CRC && run_last)
		else $error("frame_done on a byte that is not the last crc byte");

	// sync never ends a request's results
	a_sync: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && byte_kind == KIND_SYNC |-> !run_last && !frame_done)
		else $error("sync byte marked as last result");

	// length low follows sync in the very next cycle
	a_sync_len: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && byte_kind == KIND_SYNC |=> !empty && byte_kind == KIND_LEN)
		else $error("length byte did not follow sync");

endmodule

bind crc32_length_framer crclf_checker u_crclf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.out_byte   (out_byte),
	.byte_kind  (byte_kind),
	.frame_done (frame_done),
	.run_last   (run_last)
);

[dv/crc32_length_framer_tb.sv]
// testbench for crc32_length_framer: checks every framed output byte against a predictor
// of sync, length, payload and crc-32 bytes kept in a small scoreboard class
// depends on crclf_pkg and the crc32_length_framer rtl
module crc32_length_framer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import crclf_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int RANDOM_PER_STEP = 30;
	localparam int ERR_PRINT_MAX   = 20;

	typedef struct {
		logic [7:0] value;
		kind_t      kind;
		logic       done;
		logic       last;
	} frame_byte_t;

	class frame_checker;
		logic [31:0] crc_state;
		logic [7:0]  sync_byte;
		frame_byte_t expected_bytes[$];
		int          errors;
		int          requests;
		int          results;
		int          frames;

		function new();
			crc_state = CRC_ALL_ONES;
			sync_byte = SYNC_RESET;
			errors    = 0;
			requests  = 0;
			results   = 0;
			frames    = 0;
		endfunction

		function void set_sync(logic [7:0] v);
			sync_byte = v;
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction

		// reflected crc-32, one input bit per step
		function logic [31:0] crc_step(logic [31:0] acc, logic [7:0] b);
			logic fb;
			for (int i = 0; i < 8; i++) begin
				fb  = acc[0] ^ b[i];
				acc = acc >> 1;
				if (fb)
					acc = acc ^ CRC_POLY_REFL;
			end
			return acc;
		endfunction

		function void add_byte(logic [7:0] v, kind_t k, logic d);
			frame_byte_t e;
			e.value = v;
			e.kind  = k;
			e.done  = d;
			e.last  = 1'b0;
			expected_bytes.insert(expected_bytes.size(), e);
		endfunction

		function void note_request(logic [7:0] b, logic first, logic fin, logic [15:0] cnt);
			logic [15:0] len;
			logic [31:0] crc;
			requests++;
			if (first) begin
				// a header always restarts the crc, even inside a frame
				len       = cnt + LEN_EXTRA;
				crc_state = CRC_ALL_ONES;
				add_byte(sync_byte, KIND_SYNC, 1'b0);
				add_byte(len[7:0], KIND_LEN, 1'b0);
				add_byte(len[15:8], KIND_LEN, 1'b0);
			end
			add_byte(b, KIND_DATA, 1'b0);
			crc_state = crc_step(crc_state, b);
			if (fin) begin
				crc = ~crc_state;
				add_byte(crc[7:0], KIND_CRC, 1'b0);
				add_byte(crc[15:8], KIND_CRC, 1'b0);
				add_byte(crc[23:16], KIND_CRC, 1'b0);
				add_byte(crc[31:24], KIND_CRC, 1'b1);
				crc_state = CRC_ALL_ONES;
			end
			expected_bytes[expected_bytes.size() - 1].last = 1'b1;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= ERR_PRINT_MAX)
				$display("ERROR at %0t: %s", $time, msg);
		endtask

		task check_result(logic [7:0] ob, logic [1:0] k, logic d, logic l);
			frame_byte_t e;
			results++;
			if (expected_bytes.size() == 0) begin
				report($sformatf("unexpected result byte %02h kind %0d", ob, k));
				return;
			end
			e = expected_bytes.pop_front();
			if (ob !== e.value || k !== e.kind || d !== e.done || l !== e.last)
				report($sformatf("result %0d: got byte %02h kind %0d done %b last %b, want %02h %0d %b %b",
					results, ob, k, d, l, e.value, e.kind, e.done, e.last));
			else if (d)
				frames++;
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = 8'h00;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  payload_byte = 8'h00;
	logic        is_first = 1'b0;
	logic        is_final = 1'b0;
	logic [15:0] byte_count = 16'h0000;
	logic        empty;
	logic        pop = 1'b0;
	logic [7:0]  out_byte;
	logic [1:0]  byte_kind;
	logic        frame_done;
	logic        run_last;

	frame_checker sb = new();
	int cycles = 0;
	int burst_left = 0;
	int rx_mode = 0;
	int rx_left = 0;

	crc32_length_framer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.push(push),
		.full(full),
		.payload_byte(payload_byte),
		.is_first(is_first),
		.is_final(is_final),
		.byte_count(byte_count),
		.empty(empty),
		.pop(pop),
		.out_byte(out_byte),
		.byte_kind(byte_kind),
		.frame_done(frame_done),
		.run_last(run_last)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d bytes still expected", cycles, sb.pending());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// both handshakes sampled with pre-edge values
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				sb.note_request(payload_byte, is_first, is_final, byte_count);
			if (pop && !empty)
				sb.check_result(out_byte, byte_kind, frame_done, run_last);
		end
	end

	// receiver: free flow, random, sparse or fully stalled windows
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(8, 60);
		end
		rx_left--;
		case (rx_mode)
			0: pop <= 1'b1;
			1: pop <= ($urandom_range(0, 1) == 1);
			2: pop <= ($urandom_range(0, 3) == 0);
			default: pop <= 1'b0;
		endcase
	end

	task send_byte(input logic [7:0] b, input logic f, input logic l, input logic [15:0] cnt);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		push         <= 1'b1;
		payload_byte <= b;
		is_first     <= f;
		is_final     <= l;
		byte_count   <= cnt;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	// one edge first so the last request is already noted
	task wait_idle();
		push <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task write_sync(input logic [7:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		sb.set_sync(v);
		cfg_we <= 1'b0;
	endtask

	task run_directed();
		string check_str;
		check_str = "123456789";
		send_byte(8'h00, 1'b1, 1'b1, 16'd1);
		for (int i = 0; i < 9; i++)
			send_byte(check_str[i], i == 0, i == 8, 16'd9);
		send_byte(8'hFF, 1'b1, 1'b0, 16'd65531);
		send_byte(8'h55, 1'b0, 1'b0, 16'hFFFF);
		send_byte(8'hAA, 1'b0, 1'b1, 16'h0000);
		// length field wraps past 16 bits
		send_byte(8'h80, 1'b1, 1'b1, 16'd65535);
		send_byte(8'h01, 1'b1, 1'b1, 16'd65532);
		send_byte(8'h7F, 1'b1, 1'b1, 16'd0);
		// payload with no header keeps accumulating
		send_byte(8'h12, 1'b0, 1'b0, 16'h1234);
		send_byte(8'h34, 1'b0, 1'b1, 16'h0000);
		// new header abandons the open frame
		send_byte(8'hC3, 1'b1, 1'b0, 16'd5);
		send_byte(8'h3C, 1'b0, 1'b0, 16'h0000);
		send_byte(8'hE7, 1'b1, 1'b0, 16'd2);
		send_byte(8'h7E, 1'b0, 1'b1, 16'h0000);
		send_byte(8'hA5, 1'b0, 1'b1, 16'hFFFF);
	endtask

	task run_random(input int n);
		int sent;
		int kind;
		int len;
		logic [15:0] cnt;
		sent = 0;
		while (sent < n) begin
			kind = $urandom_range(0, 9);
			len  = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
			cnt  = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535)) : 16'(len);
			if (kind == 8) begin
				// stray bytes outside any frame
				len = $urandom_range(1, 3);
				for (int i = 0; i < len; i++)
					send_byte(8'($urandom_range(0, 255)), 1'b0,
						(i == len - 1) && ($urandom_range(0, 1) == 1),
						16'($urandom_range(0, 65535)));
			end else begin
				// kind 9 leaves the frame open for the next header to cut off
				for (int i = 0; i < len; i++)
					send_byte(8'($urandom_range(0, 255)), i == 0,
						(kind < 8) && (i == len - 1),
						(i == 0) ? cnt : 16'($urandom_range(0, 65535)));
			end
			sent += len;
		end
	endtask

	initial begin
		logic [7:0] last_sync;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		wait_idle();
		write_sync(8'h00);
		run_random(RANDOM_PER_STEP);
		wait_idle();
		write_sync(8'hFF);
		run_random(RANDOM_PER_STEP);
		wait_idle();
		last_sync = 8'($urandom_range(1, 254));
		write_sync(last_sync);
		run_random(RANDOM_PER_STEP);
		wait_idle();
		repeat (10) @(posedge clk);
		$display("covered %0d requests, %0d result bytes, %0d complete frames", sb.requests,
			sb.results, sb.frames);
		$display("sync bytes ed, 00, ff and %02h; %0d mismatches", last_sync, sb.errors);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[files.f]
rtl/crclf_pkg.sv
rtl/crclf_front.sv
rtl/crclf_queue.sv
rtl/crclf_back.sv
rtl/crc32_length_framer.sv
rtl/crclf_checker.sv
dv/crc32_length_framer_tb.sv
